### hw/rtl/gfmp_pkg.sv
// Shared types and constants for the generalized Fibonacci term block.
// Used by the controller, the datapath, the top level and the checker.
package gfmp_pkg;

  localparam int DEF_INDEX_BITS = 32;
  localparam int DEF_MAX_DIGITS = 9;
  localparam int SEED_W         = 30;
  localparam int INDEX_W        = 32;
  localparam int DIGIT_W        = 4;
  localparam int TERM_W         = 30;
  localparam int SEL_W          = 3;
  localparam int PROD_N         = 5;

  // operand pair codes for the serial multiplier
  localparam logic [SEL_W-1:0] SEL_SQ00  = 3'd0;
  localparam logic [SEL_W-1:0] SEL_SQ01  = 3'd1;
  localparam logic [SEL_W-1:0] SEL_SQ11  = 3'd2;
  localparam logic [SEL_W-1:0] SEL_X0001 = 3'd3;
  localparam logic [SEL_W-1:0] SEL_X0111 = 3'd4;
  localparam logic [SEL_W-1:0] SEL_FIN1  = 3'd5;
  localparam logic [SEL_W-1:0] SEL_FIN0  = 3'd6;

  localparam logic [63:0] POW10_TAB [19] = '{
    64'd1, 64'd10, 64'd100, 64'd1000, 64'd10000, 64'd100000, 64'd1000000,
    64'd10000000, 64'd100000000, 64'd1000000000, 64'd10000000000,
    64'd100000000000, 64'd1000000000000, 64'd10000000000000,
    64'd100000000000000, 64'd1000000000000000, 64'd10000000000000000,
    64'd100000000000000000, 64'd1000000000000000000
  };

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_RED,
    OP_INIT,
    OP_MUL_LD,
    OP_MUL_STEP,
    OP_MUL_STORE,
    OP_SQ_CMB,
    OP_QMUL,
    OP_BIT_NEXT,
    OP_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e           op;
    logic [SEL_W-1:0] sel;
  } dp_cmd_t;

  typedef struct packed {
    logic red_last;
    logic mul_done;
    logic ebit;
    logic bit_last;
    logic idx_zero;
  } dp_sts_t;

endpackage

### hw/rtl/gfmp_dp.sv
// Datapath: seed reduction, serial modular multiplier, matrix registers.
// Depends on gfmp_pkg; driven by gfmp_ctrl commands.
module gfmp_dp #(
  parameter int INDEX_BITS = gfmp_pkg::DEF_INDEX_BITS,
  parameter int MAX_DIGITS = gfmp_pkg::DEF_MAX_DIGITS
) (
  input  logic                         clk_i,
  input  logic [gfmp_pkg::SEED_W-1:0]  seed_first_i,
  input  logic [gfmp_pkg::SEED_W-1:0]  seed_second_i,
  input  logic [gfmp_pkg::INDEX_W-1:0] term_index_i,
  input  logic [gfmp_pkg::DIGIT_W-1:0] digit_count_i,
  input  gfmp_pkg::dp_cmd_t            cmd_i,
  output gfmp_pkg::dp_sts_t            sts_o,
  output logic [gfmp_pkg::TERM_W-1:0]  term_value_o
);
  import gfmp_pkg::*;

  localparam int VW = $clog2(POW10_TAB[MAX_DIGITS]);
  localparam int RW = SEED_W + VW;
  localparam int KW = $clog2(SEED_W);
  localparam int CW = $clog2(INDEX_BITS + 1);

  function automatic logic [VW-1:0] add_mod(input logic [VW-1:0] x, input logic [VW-1:0] y,
                                            input logic [VW-1:0] md);
    logic [VW:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, md}) s = s - {1'b0, md};
    return s[VW-1:0];
  endfunction

  logic [VW-1:0]         md_q, md_d;
  logic [SEED_W-1:0]     r0_q, r0_d, r1_q, r1_d;
  logic [KW-1:0]         k_q, k_d;
  logic [INDEX_BITS-1:0] e_q, e_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic                  zero_q, zero_d;
  logic [VW-1:0]         a00_q, a00_d, a01_q, a01_d, a11_q, a11_d;
  logic [VW-1:0]         x_q, x_d, y_q, y_d, acc_q, acc_d;
  logic [VW-1:0]         p_q [PROD_N];
  logic [VW-1:0]         res_q, res_d;

  logic [4:0]            mc;
  logic [INDEX_BITS+INDEX_W-1:0] n_ext;
  logic [INDEX_BITS-1:0] n_val;
  logic [RW-1:0]         sub_v, r0_ext, r1_ext;
  logic [VW-1:0]         t0, t1;
  logic [RW-1:0]         res_ext;
  logic [SEL_W-1:0]      dst;

  always_comb begin
    if (digit_count_i == '0) begin
      mc = 5'd1;
    end else if (int'(digit_count_i) > MAX_DIGITS) begin
      mc = 5'(MAX_DIGITS);
    end else begin
      mc = {1'b0, digit_count_i};
    end
    n_ext = {{INDEX_BITS{1'b0}}, term_index_i};
    n_val = n_ext[INDEX_BITS-1:0];
    sub_v = {{SEED_W{1'b0}}, md_q} << k_q;
    r0_ext = {{VW{1'b0}}, r0_q};
    r1_ext = {{VW{1'b0}}, r1_q};
    t0 = r0_ext[VW-1:0];
    t1 = r1_ext[VW-1:0];
    dst = (cmd_i.sel >= SEL_FIN1) ? cmd_i.sel - SEL_FIN1 : cmd_i.sel;
  end

  always_comb begin
    md_d = md_q; r0_d = r0_q; r1_d = r1_q; k_d = k_q;
    e_d = e_q; cnt_d = cnt_q; zero_d = zero_q;
    a00_d = a00_q; a01_d = a01_q; a11_d = a11_q;
    x_d = x_q; y_d = y_q; acc_d = acc_q; res_d = res_q;
    case (cmd_i.op)
      OP_LOAD: begin
        md_d   = POW10_TAB[mc][VW-1:0];
        r0_d   = seed_first_i;
        r1_d   = seed_second_i;
        k_d    = KW'(SEED_W - 1);
        zero_d = (n_val == '0);
        e_d    = n_val - 1'b1;
        cnt_d  = CW'(INDEX_BITS - 1);
      end
      OP_RED: begin
        // restoring reduction, one shifted modulus per cycle
        if (r0_ext >= sub_v) r0_d = r0_q - sub_v[SEED_W-1:0];
        if (r1_ext >= sub_v) r1_d = r1_q - sub_v[SEED_W-1:0];
        k_d = k_q - 1'b1;
      end
      OP_INIT: begin
        a00_d = VW'(1);
        a01_d = '0;
        a11_d = VW'(1);
      end
      OP_MUL_LD: begin
        acc_d = '0;
        case (cmd_i.sel)
          SEL_SQ00:  begin x_d = a00_q; y_d = a00_q; end
          SEL_SQ01:  begin x_d = a01_q; y_d = a01_q; end
          SEL_SQ11:  begin x_d = a11_q; y_d = a11_q; end
          SEL_X0001: begin x_d = a00_q; y_d = a01_q; end
          SEL_X0111: begin x_d = a01_q; y_d = a11_q; end
          SEL_FIN1:  begin x_d = t1;    y_d = a00_q; end
          SEL_FIN0:  begin x_d = t0;    y_d = a01_q; end
          default:   begin x_d = '0;    y_d = '0;    end
        endcase
      end
      OP_MUL_STEP: begin
        if (y_q[0]) acc_d = add_mod(acc_q, x_q, md_q);
        x_d = add_mod(x_q, x_q, md_q);
        y_d = y_q >> 1;
      end
      OP_SQ_CMB: begin
        // the power matrix is symmetric, so three entries describe it
        a00_d = add_mod(p_q[0], p_q[1], md_q);
        a01_d = add_mod(p_q[3], p_q[4], md_q);
        a11_d = add_mod(p_q[1], p_q[2], md_q);
      end
      OP_QMUL: begin
        a00_d = add_mod(a00_q, a01_q, md_q);
        a01_d = a00_q;
        a11_d = a01_q;
      end
      OP_BIT_NEXT: begin
        e_d   = e_q << 1;
        cnt_d = cnt_q - 1'b1;
      end
      OP_OUT: begin
        res_d = zero_q ? t0 : add_mod(p_q[0], p_q[1], md_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    md_q <= md_d; r0_q <= r0_d; r1_q <= r1_d; k_q <= k_d;
    e_q <= e_d; cnt_q <= cnt_d; zero_q <= zero_d;
    a00_q <= a00_d; a01_q <= a01_d; a11_q <= a11_d;
    x_q <= x_d; y_q <= y_d; acc_q <= acc_d; res_q <= res_d;
    if (cmd_i.op == OP_MUL_STORE) p_q[dst] <= acc_q;
  end

  always_comb begin
    sts_o.red_last = (k_q == '0);
    sts_o.mul_done = (y_q == '0);
    sts_o.ebit     = e_q[INDEX_BITS-1];
    sts_o.bit_last = (cnt_q == '0);
    sts_o.idx_zero = zero_q;
    res_ext        = {{SEED_W{1'b0}}, res_q};
    term_value_o   = res_ext[TERM_W-1:0];
  end

endmodule

### hw/rtl/gfmp_ctrl.sv
// Controller: sequences reduction, squarings, step products and output.
// Depends on gfmp_pkg; drives gfmp_dp.
module gfmp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  gfmp_pkg::dp_sts_t sts_i,
  output gfmp_pkg::dp_cmd_t cmd_o
);
  import gfmp_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RED, ST_INIT, ST_SQ_LD, ST_SQ_RUN, ST_SQ_CMB, ST_QMUL,
    ST_NEXT, ST_FIN_LD, ST_FIN_RUN, ST_DONE
  } state_e;

  state_e           state_q, state_d;
  logic [SEL_W-1:0] sel_q, sel_d;
  logic             out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    sel_d       = sel_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o.op    = OP_NOP;
    cmd_o.sel   = sel_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_RED;
        end
      end
      ST_RED: begin
        cmd_o.op = OP_RED;
        if (sts_i.red_last) state_d = ST_INIT;
      end
      ST_INIT: begin
        if (sts_i.idx_zero) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.op = OP_INIT;
          sel_d    = SEL_SQ00;
          state_d  = ST_SQ_LD;
        end
      end
      ST_SQ_LD, ST_FIN_LD: begin
        cmd_o.op = OP_MUL_LD;
        state_d  = (state_q == ST_SQ_LD) ? ST_SQ_RUN : ST_FIN_RUN;
      end
      ST_SQ_RUN: begin
        if (sts_i.mul_done) begin
          cmd_o.op = OP_MUL_STORE;
          if (sel_q == SEL_X0111) begin
            state_d = ST_SQ_CMB;
          end else begin
            sel_d   = sel_q + 1'b1;
            state_d = ST_SQ_LD;
          end
        end else begin
          cmd_o.op = OP_MUL_STEP;
        end
      end
      ST_SQ_CMB: begin
        cmd_o.op = OP_SQ_CMB;
        state_d  = sts_i.ebit ? ST_QMUL : ST_NEXT;
      end
      ST_QMUL: begin
        cmd_o.op = OP_QMUL;
        state_d  = ST_NEXT;
      end
      ST_NEXT: begin
        cmd_o.op = OP_BIT_NEXT;
        if (sts_i.bit_last) begin
          sel_d   = SEL_FIN1;
          state_d = ST_FIN_LD;
        end else begin
          sel_d   = SEL_SQ00;
          state_d = ST_SQ_LD;
        end
      end
      ST_FIN_RUN: begin
        if (sts_i.mul_done) begin
          cmd_o.op = OP_MUL_STORE;
          if (sel_q == SEL_FIN0) begin
            state_d = ST_DONE;
          end else begin
            sel_d   = SEL_FIN0;
            state_d = ST_FIN_LD;
          end
        end else begin
          cmd_o.op = OP_MUL_STEP;
        end
      end
      ST_DONE: begin
        // wait for the output register to drain
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = OP_OUT;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sel_q       <= SEL_SQ00;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

### hw/rtl/generalized_fibonacci_mod_power_top.sv
// Channel | direction | handshake            | words
// in      | input     | in_valid_i/in_ready_o | seed_first, seed_second, term_index, digit_count
// out     | output    | out_valid_o/out_ready_i | term_value
//
// One word at a time. Steps per word: load, seed reduction and init; then per index bit
// five products and a combine, a step update when the bit is set, and a bit advance;
// then two final products. The modular multiplier is bit-serial; the modulus width is 30
// bits for nine digits. Index zero skips to the output. Reset is asynchronous, active low, and clears control.
// A finished word waits in the output register while the next word is accepted.
// Top level: ties the controller to the datapath. Depends on gfmp_pkg.
module generalized_fibonacci_mod_power_top #(
  parameter int INDEX_BITS = gfmp_pkg::DEF_INDEX_BITS,
  parameter int MAX_DIGITS = gfmp_pkg::DEF_MAX_DIGITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [gfmp_pkg::SEED_W-1:0]  seed_first_i,
  input  logic [gfmp_pkg::SEED_W-1:0]  seed_second_i,
  input  logic [gfmp_pkg::INDEX_W-1:0] term_index_i,
  input  logic [gfmp_pkg::DIGIT_W-1:0] digit_count_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [gfmp_pkg::TERM_W-1:0]  term_value_o
);
  import gfmp_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  gfmp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  gfmp_dp #(
    .INDEX_BITS (INDEX_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk_i         (clk_i),
    .seed_first_i  (seed_first_i),
    .seed_second_i (seed_second_i),
    .term_index_i  (term_index_i),
    .digit_count_i (digit_count_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .term_value_o  (term_value_o)
  );

endmodule

### hw/rtl/gfmp_chk.sv
// Port-level checker for the generalized Fibonacci top level, with its bind.
// Depends on gfmp_pkg.
module gfmp_chk #(
  parameter int MAX_DIGITS = gfmp_pkg::DEF_MAX_DIGITS
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [gfmp_pkg::TERM_W-1:0] term_value_o
);
  import gfmp_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(term_value_o))
    else $error("output word dropped or changed while stalled");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second word accepted while one is in work");

  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result appeared the cycle after accept");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (64'(term_value_o) < POW10_TAB[MAX_DIGITS]))
    else $error("result not below the largest modulus");

endmodule

bind generalized_fibonacci_mod_power_top gfmp_chk #(.MAX_DIGITS(MAX_DIGITS)) u_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .term_value_o (term_value_o)
);

### tb/tb_top.sv
// Self-checking bench for generalized_fibonacci_mod_power_top.
// Random and directed queries checked against a matrix-power predictor.
// Depends on gfmp_pkg and the top level.
`timescale 1ns / 1ps

module tb_top;
  import gfmp_pkg::*;

  typedef struct packed {
    logic [SEED_W-1:0]  seed0;
    logic [SEED_W-1:0]  seed1;
    logic [INDEX_W-1:0] idx;
    logic [DIGIT_W-1:0] digits;
  } query_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [SEED_W-1:0]   seed_first_i;
  logic [SEED_W-1:0]   seed_second_i;
  logic [INDEX_W-1:0]  term_index_i;
  logic [DIGIT_W-1:0]  digit_count_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [TERM_W-1:0]   term_value_o;

  query_t             pending_q[$];
  logic [TERM_W-1:0]  term_q[$];
  int                 err_cnt = 0;
  int                 got_cnt = 0;
  bit                 stim_done = 0;
  int                 gap_left = 0;
  int                 burst_left = 0;
  int                 hold_left = 0;
  int                 cyc = 0;

  generalized_fibonacci_mod_power_top dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [63:0] mulmod(logic [63:0] x, logic [63:0] y, logic [63:0] md);
    return (x * y) % md;
  endfunction

  function automatic logic [TERM_W-1:0] fib_term(query_t q);
    logic [63:0] md, t0, t1, a00, a01, a10, a11, b00, b01, b10, b11, e;
    int m;
    m = q.digits;
    if (m < 1) m = 1;
    if (m > DEF_MAX_DIGITS) m = DEF_MAX_DIGITS;
    md = 1;
    for (int i = 0; i < m; i++) md = md * 10;
    t0 = q.seed0 % md;
    t1 = q.seed1 % md;
    if (q.idx == 0) return t0[TERM_W-1:0];
    e = q.idx - 1;
    a00 = 1; a01 = 0; a10 = 0; a11 = 1;
    for (int b = DEF_INDEX_BITS - 1; b >= 0; b--) begin
      b00 = (mulmod(a00, a00, md) + mulmod(a01, a10, md)) % md;
      b01 = (mulmod(a00, a01, md) + mulmod(a01, a11, md)) % md;
      b10 = (mulmod(a10, a00, md) + mulmod(a11, a10, md)) % md;
      b11 = (mulmod(a10, a01, md) + mulmod(a11, a11, md)) % md;
      if (e[b]) begin
        // multiply by [[1,1],[1,0]]
        a00 = (b00 + b01) % md; a01 = b00;
        a10 = (b10 + b11) % md; a11 = b10;
      end else begin
        a00 = b00; a01 = b01; a10 = b10; a11 = b11;
      end
    end
    return TERM_W'((mulmod(t1, a00, md) + mulmod(t0, a01, md)) % md);
  endfunction

  function automatic query_t rand_query();
    query_t q;
    q.seed0 = SEED_W'($urandom);
    q.seed1 = SEED_W'($urandom);
    case ($urandom_range(0, 3))
      0: q.idx = $urandom_range(0, 20);
      1: q.idx = $urandom_range(0, 4000);
      default: q.idx = $urandom;
    endcase
    q.digits = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(1, 9));
    return q;
  endfunction

  initial begin
    query_t q;
    // directed: index zero, one and all-ones, extremes of seeds, all digit counts
    for (int d = 0; d < 16; d++) begin
      q.seed0 = 30'h3FFF_FFFF; q.seed1 = 30'h3FFF_FFFF;
      q.idx = (d % 3 == 0) ? 32'hFFFF_FFFF : INDEX_W'(d % 3 - 1); q.digits = DIGIT_W'(d);
      pending_q.push_back(q);
    end
    q = '0;               pending_q.push_back(q);
    q.idx = 1; q.digits = 4'd9; pending_q.push_back(q);
    q.seed0 = SEED_W'(999999999); q.seed1 = SEED_W'(999999999); q.idx = 2;
    pending_q.push_back(q);
    q.idx = 32'h8000_0000; pending_q.push_back(q);
    q.seed0 = '0; q.seed1 = SEED_W'(1); q.idx = 50; q.digits = 4'd9; pending_q.push_back(q);
    for (int i = 0; i < 300; i++) pending_q.push_back(rand_query());
    stim_done = 1;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // driver: bursts with gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      seed_first_i <= '0; seed_second_i <= '0; term_index_i <= '0; digit_count_i <= '0;
    end else begin
      if (!in_valid_i || in_ready_o) begin
        if (in_valid_i) term_q.push_back(fib_term({seed_first_i, seed_second_i,
                                                   term_index_i, digit_count_i}));
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending_q.size() > 0) begin
          query_t nq;
          nq = pending_q.pop_front();
          in_valid_i <= 1'b1;
          {seed_first_i, seed_second_i, term_index_i, digit_count_i} <= nq;
          if (burst_left > 0) burst_left <= burst_left - 1;
          else begin
            burst_left <= $urandom_range(0, 6);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 300);
          end
        end else in_valid_i <= 1'b0;
      end
    end
  end

  // monitor with its own stall pattern and one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      cyc <= cyc + 1;
      if (out_valid_o && out_ready_i) begin
        got_cnt <= got_cnt + 1;
        if (term_q.size() == 0) begin
          $display("%0t: unexpected word, actual %0d", $time, term_value_o);
          err_cnt <= err_cnt + 1;
        end else begin
          logic [TERM_W-1:0] exp_v;
          exp_v = term_q.pop_front();
          if (exp_v !== term_value_o) begin
            $display("%0t: term_value mismatch expected %0d actual %0d",
                     $time, exp_v, term_value_o);
            err_cnt <= err_cnt + 1;
          end
        end
      end
      if (cyc == 3000) hold_left <= 20000;
      else if (hold_left > 0) hold_left <= hold_left - 1;
      if (hold_left > 0 || cyc == 3000) out_ready_i <= 1'b0;
      else if (cyc % 2000 < 600) out_ready_i <= 1'b1;
      else out_ready_i <= ($urandom_range(0, 3) != 0);
    end
  end

  initial begin
    wait (stim_done);
    @(negedge clk_i);
    // look between edges so queue and valid updates have settled
    while (pending_q.size() > 0 || in_valid_i || term_q.size() > 0) @(negedge clk_i);
    repeat (3000) @(posedge clk_i);
    $display("Ran %0d queries, all index widths and digit counts 0..15.", got_cnt);
    if (err_cnt == 0 && term_q.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #150ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule

### sim.f
hw/rtl/gfmp_pkg.sv
hw/rtl/gfmp_dp.sv
hw/rtl/gfmp_ctrl.sv
hw/rtl/generalized_fibonacci_mod_power_top.sv
hw/rtl/gfmp_chk.sv
tb/tb_top.sv
